### hw/rtl/pbkdf2_hmac_sha256_key_derive_macros.svh
// Assertion macros shared by the key derivation RTL.
// Depends on nothing; included by files that assert.
`ifndef PBKDF2_HMAC_SHA256_KEY_DERIVE_MACROS_SVH
`define PBKDF2_HMAC_SHA256_KEY_DERIVE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define PKD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define PKD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### hw/rtl/pkd_pkg.sv
// Package for the key derivation block: SHA-256 constants, functions, command types.
// Depends on nothing.
package pkd_pkg;
  localparam int DIGEST_BYTES    = 32;
  localparam int KEY_BLOCK_BYTES = 64;
  localparam logic [31:0] INNER_PAD_WORD  = 32'h36363636;
  localparam logic [31:0] OUTER_PAD_WORD  = 32'h5c5c5c5c;
  localparam logic [31:0] BLOCK_INDEX_ONE = 32'h00000001;
  localparam logic [31:0] PAD_MARK        = 32'h80000000;
  localparam logic [31:0] LEN_SALT  = 32'((KEY_BLOCK_BYTES + 12) * 8);
  localparam logic [31:0] LEN_INNER = 32'((KEY_BLOCK_BYTES + DIGEST_BYTES) * 8);

  // Input item modes and register indexes.
  localparam logic       MODE_LOAD  = 1'b0;
  localparam logic       MODE_START = 1'b1;
  localparam logic [0:0] REG_SALT   = 1'b0;
  localparam logic [0:0] REG_ITER   = 1'b1;

  localparam logic [255:0] INITIAL_HASH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [0:63][31:0] ROUND_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  // Message block source for one compression.
  typedef enum logic [2:0] {
    SRC_INNER_KEY, SRC_OUTER_KEY, SRC_SALT, SRC_U_VALUE, SRC_DIGEST
  } blk_src_e;

  // Chaining value a compression starts from, and where its result goes.
  typedef enum logic [2:0] {
    DST_INNER_PAD, DST_OUTER_PAD, DST_MID, DST_U_VALUE
  } blk_dst_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_ROUND, ST_FINISH, ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic     load;      // start a compression: load state and block
    blk_src_e src;
    blk_dst_e dst;
    logic     round;     // advance one round
    logic     finish;    // add chaining value, store result
    logic     clr_acc;   // new derivation
    logic     acc_u;     // fold U value into accumulator
  } dp_cmd_t;

  typedef struct packed {
    logic round_last;  // current round is round 63
  } dp_stat_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction
endpackage

### hw/rtl/pkd_datapath.sv
// SHA-256 round datapath: one round per cycle, pad states, U value, accumulator.
// Depends on pkd_pkg.
module pkd_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pkd_pkg::dp_cmd_t  cmd_i,
  output pkd_pkg::dp_stat_t stat_o,
  input  logic [63:0]       pw_store_i [8],
  input  logic [63:0]       salt_i,
  output logic [255:0]      acc_o
);
  import pkd_pkg::*;

  logic [31:0]  w_q [16];
  logic [255:0] st_q, base_q, inner_q, outer_q, mid_q, u_q, acc_q;
  logic [5:0]   rnd_q;
  blk_dst_e     dst_q;
  logic [0:15][31:0] blk;
  logic [255:0] base_sel;
  logic [31:0]  a, b, c, d, e, f, g, h, w, t1, t2, w2, w15, s0, s1;
  logic [255:0] sum;

  always_comb begin
    blk = '0;
    base_sel = inner_q;
    for (int i = 0; i < 8; i++) begin
      case (cmd_i.src)
        SRC_INNER_KEY: begin
          blk[2*i]   = pw_store_i[i][63:32] ^ INNER_PAD_WORD;
          blk[2*i+1] = pw_store_i[i][31:0] ^ INNER_PAD_WORD;
        end
        SRC_OUTER_KEY: begin
          blk[2*i]   = pw_store_i[i][63:32] ^ OUTER_PAD_WORD;
          blk[2*i+1] = pw_store_i[i][31:0] ^ OUTER_PAD_WORD;
        end
        default: ;
      endcase
    end
    case (cmd_i.src)
      SRC_SALT: begin
        blk[0] = salt_i[63:32]; blk[1] = salt_i[31:0];
        blk[2] = BLOCK_INDEX_ONE; blk[3] = PAD_MARK; blk[15] = LEN_SALT;
      end
      SRC_U_VALUE: begin
        for (int i = 0; i < 8; i++) blk[i] = u_q[255-32*i -: 32];
        blk[8] = PAD_MARK; blk[15] = LEN_INNER;
      end
      SRC_DIGEST: begin
        for (int i = 0; i < 8; i++) blk[i] = mid_q[255-32*i -: 32];
        blk[8] = PAD_MARK; blk[15] = LEN_INNER;
      end
      default: ;
    endcase
    case (cmd_i.dst)
      DST_INNER_PAD, DST_OUTER_PAD: base_sel = INITIAL_HASH;
      DST_MID:     base_sel = inner_q;
      DST_U_VALUE: base_sel = outer_q;
      default:     base_sel = inner_q;
    endcase
  end

  assign {a, b, c, d, e, f, g, h} = st_q;
  assign w2  = w_q[4'(rnd_q - 6'd2)];
  assign w15 = w_q[4'(rnd_q - 6'd15)];
  assign s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
  assign s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
  // Schedule words are preloaded, so the first 16 rounds read the block directly.
  assign w   = (rnd_q < 6'd16) ? w_q[rnd_q[3:0]]
                               : s1 + w_q[4'(rnd_q - 6'd7)] + s0 + w_q[rnd_q[3:0]];
  assign t1  = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
             + ROUND_K[rnd_q] + w;
  assign t2  = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));

  always_comb begin
    for (int i = 0; i < 8; i++)
      sum[255-32*i -: 32] = st_q[255-32*i -: 32] + base_q[255-32*i -: 32];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < 16; i++) w_q[i] <= blk[i];
      st_q   <= base_sel;
      base_q <= base_sel;
      dst_q  <= cmd_i.dst;
    end else if (cmd_i.round) begin
      w_q[rnd_q[3:0]] <= w;
      st_q <= {t1 + t2, a, b, c, d + t1, e, f, g};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q   <= '0;
      inner_q <= '0;
      outer_q <= '0;
      mid_q   <= '0;
      u_q     <= '0;
      acc_q   <= '0;
    end else begin
      if (cmd_i.load)       rnd_q <= '0;
      else if (cmd_i.round) rnd_q <= rnd_q + 6'd1;
      if (cmd_i.finish) begin
        case (dst_q)
          DST_INNER_PAD: inner_q <= sum;
          DST_OUTER_PAD: outer_q <= sum;
          DST_MID:       mid_q   <= sum;
          DST_U_VALUE:   u_q     <= sum;
          default: ;
        endcase
      end
      if (cmd_i.clr_acc)    acc_q <= '0;
      else if (cmd_i.acc_u) acc_q <= acc_q ^ u_q;
    end
  end

  assign stat_o.round_last = (rnd_q == 6'd63);
  assign acc_o = acc_q;
endmodule

### hw/rtl/pkd_ctrl.sv
// Sequencer for pad setup, HMAC iterations and key word output.
// Depends on pkd_pkg and the assertion macro header.
`include "pbkdf2_hmac_sha256_key_derive_macros.svh"
module pkd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [31:0]       iter_count_i,
  input  pkd_pkg::dp_stat_t stat_i,
  output pkd_pkg::dp_cmd_t  cmd_o,
  output logic              busy_o,
  output logic              out_valid_o,
  output logic [1:0]        out_sel_o,
  input  logic              out_stall_i
);
  import pkd_pkg::*;

  ctrl_state_e state_q, state_d;
  logic [1:0]  step_q, step_d;   // 0 inner pad, 1 outer pad, 2 inner hash, 3 outer hash
  logic [31:0] iter_q, iter_d;
  logic [1:0]  sel_q, sel_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      iter_q  <= '0;
      sel_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      iter_q  <= iter_d;
      sel_q   <= sel_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    iter_d  = iter_q;
    sel_d   = sel_q;
    cmd_o   = '0;
    cmd_o.src = SRC_INNER_KEY;
    cmd_o.dst = DST_INNER_PAD;
    case (step_q)
      2'd0: begin cmd_o.src = SRC_INNER_KEY; cmd_o.dst = DST_INNER_PAD; end
      2'd1: begin cmd_o.src = SRC_OUTER_KEY; cmd_o.dst = DST_OUTER_PAD; end
      2'd2: begin
        cmd_o.src = (iter_q == '0) ? SRC_SALT : SRC_U_VALUE;
        cmd_o.dst = DST_MID;
      end
      default: begin cmd_o.src = SRC_DIGEST; cmd_o.dst = DST_U_VALUE; end
    endcase
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.clr_acc = 1'b1;
          step_d  = '0;
          iter_d  = '0;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (step_q >= 2'd2 && iter_q == iter_count_i) begin
          sel_d   = '0;
          state_d = ST_OUT;
        end else begin
          cmd_o.load = 1'b1;
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        if (stat_i.round_last) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d = ST_LOAD;
        if (step_q == 2'd3) begin
          step_d = 2'd2;
          iter_d = iter_q + 32'd1;
        end else begin
          step_d = step_q + 2'd1;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          sel_d = sel_q + 2'd1;
          if (sel_q == 2'd3) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // U value is registered by its finish; fold it in at the next load state.
    if (state_q == ST_LOAD && step_q == 2'd2 && iter_q != '0) cmd_o.acc_u = 1'b1;
  end

  // acc_u also fires on the exit path; guard it to exactly once per iteration.
  assign busy_o      = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign out_sel_o   = sel_q;

  `PKD_ASSERT_NXT(a_start_busy, clk_i, rst_ni, state_q == ST_IDLE && start_i,
    state_q == ST_LOAD, "start did not leave idle")
  `PKD_ASSERT_IMP(a_load_round, clk_i, rst_ni, cmd_o.load && cmd_o.round, 1'b0,
    "load and round together")
  `PKD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(sel_q), "output moved while stalled")
endmodule

### hw/rtl/pbkdf2_hmac_sha256_key_derive.sv
// PBKDF2-HMAC-SHA-256 key derivation, one 32-byte block, four 64-bit key words out.
// Load items (mode 0) write one 64-bit password word per cycle while the block is not busy.
// A start item (mode 1) runs the derivation, then the four key words leave one per
// unstalled cycle. The run time is set by the single SHA-256 round unit, which runs
// one round per cycle between a load state and a final add state per compression:
// two compressions build the pads, two more per iteration. No input item is accepted
// from the start until the last key word is taken; register writes are not held off.
// Depends on pkd_pkg, pkd_datapath, pkd_ctrl.
module pbkdf2_hmac_sha256_key_derive (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [2:0]  word_index_i,
  input  logic [63:0] password_word_i,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] key_word_o,
  output logic        last_word_o
);
  import pkd_pkg::*;

  logic [63:0]  salt_q;
  logic [31:0]  iter_q;
  logic [63:0]  pw_q [8];
  logic         in_acc, busy;
  logic [1:0]   sel;
  logic [255:0] acc;
  dp_cmd_t      cmd;
  dp_stat_t     stat;

  // Hold input while a derivation runs or its key words drain.
  assign in_stall_o = busy;
  assign in_acc     = in_valid_i && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      salt_q <= '0;
      iter_q <= 32'd1;
      for (int i = 0; i < 8; i++) pw_q[i] <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_SALT: salt_q <= cfg_data_i;
          REG_ITER: iter_q <= cfg_data_i[31:0];
          default: ;
        endcase
      end
      if (in_acc && mode_i == MODE_LOAD) pw_q[word_index_i] <= password_word_i;
    end
  end

  pkd_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .start_i(in_acc && mode_i == MODE_START),
    .iter_count_i(iter_q),
    .stat_i(stat),
    .cmd_o(cmd),
    .busy_o(busy),
    .out_valid_o,
    .out_sel_o(sel),
    .out_stall_i
  );

  pkd_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd),
    .stat_o(stat),
    .pw_store_i(pw_q),
    .salt_i(salt_q),
    .acc_o(acc)
  );

  // Word 0 holds key bytes 0-7, the most significant end of the accumulator.
  assign key_word_o  = acc[255 - 64*sel -: 64];
  assign last_word_o = (sel == 2'd3);
endmodule

### bench/pbkdf2_hmac_sha256_key_derive_checker.sv
// Checker for the key derivation block: watches both channels and the register port.
// Predicts the four key words of each start item and compares them in order.
// Depends on pkd_pkg for the SHA-256 constants, input modes and register indexes.
`timescale 1ns / 100ps

module pbkdf2_hmac_sha256_key_derive_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        mode_i,
  input  logic [2:0]  word_index_i,
  input  logic [63:0] password_word_i,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [63:0] key_word_i,
  input  logic        last_word_i,
  output int          pending_o,
  output int          errors_o
);
  import pkd_pkg::*;

  typedef struct packed {
    logic [63:0] key_word;
    logic        last_word;
  } key_out_t;

  logic [63:0]       salt_mirror;
  logic [31:0]       iter_mirror;
  logic [7:0][63:0]  password_mirror;
  key_out_t          key_words_q[$];

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    logic [63:0] twice;
    twice = {x, x} >> n;
    return twice[31:0];
  endfunction

  function automatic logic [7:0][31:0] sha_compress(input logic [7:0][31:0] chain,
                                                    input logic [15:0][31:0] msg);
    logic [63:0][31:0] w;
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    logic [7:0][31:0] res;
    for (int t = 0; t < 16; t++) w[t] = msg[t];
    for (int t = 16; t < 64; t++) begin
      s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                chain[4], chain[5], chain[6], chain[7]};
    for (int t = 0; t < 64; t++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
         + ROUND_K[t] + w[t];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    res[0] = chain[0] + a; res[1] = chain[1] + b; res[2] = chain[2] + c;
    res[3] = chain[3] + d; res[4] = chain[4] + e; res[5] = chain[5] + f;
    res[6] = chain[6] + g; res[7] = chain[7] + h;
    return res;
  endfunction

  // Full PBKDF2 block 1 from the mirrored password, salt and iteration count.
  function automatic logic [7:0][31:0] derive_key(input logic [7:0][63:0] pwd,
                                                  input logic [63:0] salt,
                                                  input logic [31:0] iters);
    logic [15:0][31:0] ipad_blk, opad_blk, msg;
    logic [7:0][31:0]  iv, istate, ostate, u, acc, mid;
    for (int i = 0; i < 8; i++) iv[i] = INITIAL_HASH[255 - 32*i -: 32];
    for (int i = 0; i < 8; i++) begin
      ipad_blk[2*i]   = pwd[i][63:32] ^ INNER_PAD_WORD;
      ipad_blk[2*i+1] = pwd[i][31:0]  ^ INNER_PAD_WORD;
      opad_blk[2*i]   = pwd[i][63:32] ^ OUTER_PAD_WORD;
      opad_blk[2*i+1] = pwd[i][31:0]  ^ OUTER_PAD_WORD;
    end
    istate = sha_compress(iv, ipad_blk);
    ostate = sha_compress(iv, opad_blk);
    acc = '0;
    u = '0;
    for (int n = 0; n < iters; n++) begin
      msg = '0;
      if (n == 0) begin
        msg[0] = salt[63:32];
        msg[1] = salt[31:0];
        msg[2] = BLOCK_INDEX_ONE;
        msg[3] = PAD_MARK;
        msg[15] = LEN_SALT;
      end else begin
        for (int i = 0; i < 8; i++) msg[i] = u[i];
        msg[8] = PAD_MARK;
        msg[15] = LEN_INNER;
      end
      mid = sha_compress(istate, msg);
      msg = '0;
      for (int i = 0; i < 8; i++) msg[i] = mid[i];
      msg[8] = PAD_MARK;
      msg[15] = LEN_INNER;
      u = sha_compress(ostate, msg);
      acc = acc ^ u;
    end
    return acc;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [7:0][31:0] acc;
    key_out_t         exp_word;
    if (!rst_ni) begin
      salt_mirror = '0;
      iter_mirror = 32'd1;
      password_mirror = '0;
      key_words_q.delete();
      errors_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_SALT) salt_mirror = cfg_data_i;
        else if (cfg_index_i == REG_ITER) iter_mirror = cfg_data_i[31:0];
      end
      if (in_valid_i && !in_stall_i) begin
        if (mode_i == MODE_LOAD) begin
          password_mirror[word_index_i] = password_word_i;
        end else if (mode_i == MODE_START) begin
          acc = derive_key(password_mirror, salt_mirror, iter_mirror);
          for (int k = 0; k < 4; k++)
            key_words_q.push_back('{key_word: {acc[2*k], acc[2*k+1]}, last_word: k == 3});
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (key_words_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10)
            $display("%0t: unexpected key word %h last %b", $time, key_word_i, last_word_i);
        end else begin
          exp_word = key_words_q.pop_front();
          if (exp_word.key_word !== key_word_i || exp_word.last_word !== last_word_i) begin
            errors_o++;
            if (errors_o <= 10)
              $display("%0t: key word mismatch: expected %h last %b, got %h last %b",
                       $time, exp_word.key_word, exp_word.last_word, key_word_i, last_word_i);
          end
        end
      end
    end
    pending_o = key_words_q.size();
  end

endmodule

### bench/pbkdf2_hmac_sha256_key_derive_tb.sv
// Top of the key derivation bench: clock, reset, stimulus, receiver stalls, verdict.
// Depends on pkd_pkg, the block under test and pbkdf2_hmac_sha256_key_derive_checker.
`timescale 1ns / 100ps

module pbkdf2_hmac_sha256_key_derive_tb;
  import pkd_pkg::*;

  localparam int         CYCLE_LIMIT = 1500000;
  localparam int         LONG_HOLD = 3000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        mode_i = MODE_LOAD;
  logic [2:0]  word_index_i = '0;
  logic [63:0] password_word_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_index_i = REG_SALT;
  logic [63:0] cfg_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [63:0] key_word_o;
  logic        last_word_o;

  int pending;
  int errors;
  int cycle_count = 0;
  int loads_sent = 0;
  int starts_sent = 0;
  int cfg_writes = 0;
  bit quiet = 1'b0;      // no idling on either side
  bit hold_req = 1'b0;   // ask the receiver for one long hold-off

  always #5 clk_i = ~clk_i;

  pbkdf2_hmac_sha256_key_derive dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .mode_i, .word_index_i, .password_word_i,
    .cfg_we_i, .cfg_index_i, .cfg_data_i, .out_valid_o, .out_stall_i, .key_word_o,
    .last_word_o
  );

  pbkdf2_hmac_sha256_key_derive_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .mode_i, .word_index_i,
    .password_word_i, .cfg_we_i, .cfg_index_i, .cfg_data_i, .out_valid_i(out_valid_o),
    .out_stall_i, .key_word_i(key_word_o), .last_word_i(last_word_o),
    .pending_o(pending), .errors_o(errors)
  );

  // Guard against a hung block.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none when quiet.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Offer one item, with an optional idle burst ahead of it; return at its accepting edge.
  task automatic send_item(input logic mode, input logic [2:0] idx, input logic [63:0] word);
    if (!quiet && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    word_index_i <= idx;
    password_word_i <= word;
    do @(posedge clk_i); while (in_stall_o);
    if (mode == MODE_LOAD) loads_sent++;
    else starts_sent++;
  endtask

  // Drop valid and hold until every key word is back and the block has settled.
  task automatic drain;
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [63:0] data);
    drain();
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_writes++;
  endtask

  // Random iteration count: mostly short, sometimes zero.
  function automatic logic [63:0] pick_iters();
    logic [63:0] v;
    v = {$urandom, $urandom};
    v[31:0] = ($urandom_range(0, 7) == 0) ? 32'd0 : 32'($urandom_range(1, 4));
    return v;
  endfunction

  initial begin
    int phase;
    int items;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: derive from the reset configuration and an all-zero password.
    send_item(MODE_START, 3'd5, 64'hffff_ffff_ffff_ffff);
    // Fill every slot of the store, mostly with extreme patterns.
    send_item(MODE_LOAD, 3'd0, 64'hffff_ffff_ffff_ffff);
    send_item(MODE_LOAD, 3'd1, 64'h0000_0000_0000_0000);
    send_item(MODE_LOAD, 3'd2, 64'haaaa_aaaa_aaaa_aaaa);
    send_item(MODE_LOAD, 3'd3, 64'h5555_5555_5555_5555);
    send_item(MODE_LOAD, 3'd4, 64'h8000_0000_0000_0001);
    send_item(MODE_LOAD, 3'd5, 64'h0123_4567_89ab_cdef);
    send_item(MODE_LOAD, 3'd6, 64'h7fff_ffff_ffff_fffe);
    send_item(MODE_LOAD, 3'd7, 64'hffff_ffff_ffff_ffff);
    send_item(MODE_START, 3'd0, 64'h0);
    // Derive again with the store untouched.
    send_item(MODE_START, 3'd7, 64'h1234);
    write_reg(REG_SALT, 64'hffff_ffff_ffff_ffff);
    write_reg(REG_ITER, 64'hffff_ffff_0000_0002);
    send_item(MODE_START, 3'd0, 64'h0);
    // Zero iterations give an all-zero key.
    write_reg(REG_ITER, 64'h0);
    send_item(MODE_START, 3'd0, 64'h0);
    // Rewrite slots 0, 1 and 7, slot 0 with zero bytes inside; slots 2 to 6 keep their words.
    write_reg(REG_SALT, 64'h0);
    write_reg(REG_ITER, 64'd1);
    send_item(MODE_LOAD, 3'd0, 64'h7061_7300_7764_0000);
    send_item(MODE_LOAD, 3'd1, 64'h0);
    send_item(MODE_LOAD, 3'd7, 64'h0);
    // Long receiver hold-off while the sender keeps offering: the block backs up.
    hold_req = 1'b1;
    send_item(MODE_START, 3'd0, 64'h0);
    send_item(MODE_LOAD, 3'd2, {$urandom, $urandom});
    send_item(MODE_LOAD, 3'd3, {$urandom, $urandom});
    send_item(MODE_START, 3'd0, 64'h0);
    // Deep run, once.
    write_reg(REG_ITER, 64'd40);
    send_item(MODE_START, 3'd0, 64'h0);

    // Random phases: new salt or iteration count at times, then runs of zero to eight loads, each closed by a start.
    items = 0;
    phase = 0;
    while (items < 100) begin
      if (items > 80) quiet = 1'b1;
      if ($urandom_range(0, 1) == 0) write_reg(REG_SALT, {$urandom, $urandom});
      if (phase % 2 == 0) write_reg(REG_ITER, pick_iters());
      repeat ($urandom_range(1, 3)) begin
        repeat ($urandom_range(0, 8)) begin
          send_item(MODE_LOAD, 3'($urandom_range(0, 7)), {$urandom, $urandom});
          items++;
        end
        send_item(MODE_START, 3'($urandom_range(0, 7)), {$urandom, $urandom});
        items++;
      end
      phase++;
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d password loads and %0d derivations over %0d register writes,",
             loads_sent, starts_sent, cfg_writes);
    $display("iteration counts from zero to forty, with stalls on both sides.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
